FILE: hdl/rcwc_pkg.sv
// rcwc_pkg: types, constants and sine table for raycast_wall_column.
// No dependencies.
package rcwc_pkg;

    localparam int MAP_SIZE_DEF  = 8;
    localparam int MAX_STEPS_DEF = 12;

    localparam logic [63:0] WALL_MAP_RST = 64'hFF818181818181FF;
    localparam logic [14:0] FOV_RST      = 15'd10923;
    localparam logic [10:0] RAYS_RST     = 11'd120;
    localparam logic [7:0]  SCALE_RST    = 8'd16;

    localparam logic [1:0] REG_WALL_MAP = 2'd0;
    localparam logic [1:0] REG_FOV      = 2'd1;
    localparam logic [1:0] REG_RAYS     = 2'd2;
    localparam logic [1:0] REG_SCALE    = 2'd3;

    typedef struct packed {
        logic [14:0] pos_x;
        logic [14:0] pos_y;
        logic [15:0] view_angle;
        logic [9:0]  column;
    } rcwc_in_t;

    typedef struct packed {
        logic [11:0] wall_height;
        logic        height_saturated;
        logic [3:0]  step_count;
        logic        left_map;
    } rcwc_out_t;

    // quarter-wave sine, Q1.14
    function automatic logic [14:0] sin_quarter(input logic [6:0] k);
        logic [14:0] v;
        case (k)
            7'd0: v = 15'd0;       7'd1: v = 15'd402;     7'd2: v = 15'd804;
            7'd3: v = 15'd1205;    7'd4: v = 15'd1606;    7'd5: v = 15'd2006;
            7'd6: v = 15'd2404;    7'd7: v = 15'd2801;    7'd8: v = 15'd3196;
            7'd9: v = 15'd3590;    7'd10: v = 15'd3981;   7'd11: v = 15'd4370;
            7'd12: v = 15'd4756;   7'd13: v = 15'd5139;   7'd14: v = 15'd5520;
            7'd15: v = 15'd5897;   7'd16: v = 15'd6270;   7'd17: v = 15'd6639;
            7'd18: v = 15'd7005;   7'd19: v = 15'd7366;   7'd20: v = 15'd7723;
            7'd21: v = 15'd8076;   7'd22: v = 15'd8423;   7'd23: v = 15'd8765;
            7'd24: v = 15'd9102;   7'd25: v = 15'd9434;   7'd26: v = 15'd9760;
            7'd27: v = 15'd10080;  7'd28: v = 15'd10394;  7'd29: v = 15'd10702;
            7'd30: v = 15'd11003;  7'd31: v = 15'd11297;  7'd32: v = 15'd11585;
            7'd33: v = 15'd11866;  7'd34: v = 15'd12140;  7'd35: v = 15'd12406;
            7'd36: v = 15'd12665;  7'd37: v = 15'd12916;  7'd38: v = 15'd13160;
            7'd39: v = 15'd13395;  7'd40: v = 15'd13623;  7'd41: v = 15'd13842;
            7'd42: v = 15'd14053;  7'd43: v = 15'd14256;  7'd44: v = 15'd14449;
            7'd45: v = 15'd14635;  7'd46: v = 15'd14811;  7'd47: v = 15'd14978;
            7'd48: v = 15'd15137;  7'd49: v = 15'd15286;  7'd50: v = 15'd15426;
            7'd51: v = 15'd15557;  7'd52: v = 15'd15679;  7'd53: v = 15'd15791;
            7'd54: v = 15'd15893;  7'd55: v = 15'd15986;  7'd56: v = 15'd16069;
            7'd57: v = 15'd16143;  7'd58: v = 15'd16207;  7'd59: v = 15'd16261;
            7'd60: v = 15'd16305;  7'd61: v = 15'd16340;  7'd62: v = 15'd16364;
            7'd63: v = 15'd16379;  7'd64: v = 15'd16384;
            default: v = 15'd0;
        endcase
        return v;
    endfunction

    // signed Q1.14 sine of a binary angle, 256 steps per turn
    function automatic logic signed [15:0] sin_q14(input logic [15:0] ang);
        logic [7:0]  idx;
        logic [14:0] mag;
        idx = ang[15:8];
        if (idx[6]) mag = sin_quarter(7'd64 - {1'b0, idx[5:0]});
        else        mag = sin_quarter({1'b0, idx[5:0]});
        return idx[7] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
    endfunction

endpackage

FILE: hdl/rcwc_divider.sv
// rcwc_divider: restoring divider, one quotient bit per cycle.
// Depends on nothing.
module rcwc_divider #(
    parameter int NW = 25,
    parameter int DW = 19
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          start,
    input  logic [NW-1:0] numer,
    input  logic [DW-1:0] denom,
    output logic          done,
    output logic [NW-1:0] quot
);
    localparam int CW = $clog2(NW + 1);

    logic [NW-1:0] q_reg, q_next;
    logic [DW:0]   r_reg, r_next;
    logic [DW-1:0] d_reg;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic [DW:0]   trial;

    always_comb begin
        q_next    = q_reg;
        r_next    = r_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        trial     = {r_reg[DW-1:0], q_reg[NW-1]};
        if (start) begin
            q_next    = numer;
            r_next    = '0;
            cnt_next  = CW'(NW);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (trial >= {1'b0, d_reg}) begin
                r_next = trial - {1'b0, d_reg};
                q_next = {q_reg[NW-2:0], 1'b1};
            end else begin
                r_next = trial;
                q_next = {q_reg[NW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1)) busy_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
        q_reg <= q_next;
        r_reg <= r_next;
        if (start) d_reg <= denom;
    end

    assign done = busy_reg && (cnt_reg == CW'(1));
    assign quot = {q_reg[NW-2:0], (trial >= {1'b0, d_reg})};
endmodule

FILE: hdl/raycast_wall_column.sv
// raycast_wall_column: top level, wall height for one screen column.
// Depends on rcwc_pkg and rcwc_divider.
//
// One request names a viewer position, heading and screen column; the block
// returns the projected wall height for that column. Work is sequential, one
// request at a time, s_ready low while busy. Both divisions share one
// restoring divider (25-bit numerator, one bit a cycle). A request passes
// through these steps in order: accept, the column offset division
// (column*fov / ray_count), direction setup, the ray walk (1..MAX_STEPS
// steps), the fish-eye multiply, the height division and the load of the
// output register. A non-positive corrected distance skips the height
// division. The result waits in the output register while m_ready is low;
// the next request is accepted meanwhile, but its result cannot be loaded
// until the waiting one has left. Configuration writes take effect at once
// and must only happen while idle. The wall map reset holds border walls.
module raycast_wall_column
    import rcwc_pkg::*;
#(
    parameter int MAP_SIZE  = MAP_SIZE_DEF,
    parameter int MAX_STEPS = MAX_STEPS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  rcwc_in_t    s_data,
    output logic        m_valid,
    input  logic        m_ready,
    output rcwc_out_t   m_data,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [63:0] cfg_data
);
    localparam int SW   = $clog2(MAX_STEPS + 1);
    localparam int LIM  = MAP_SIZE << 14;
    localparam int NUMW = 25;

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_ODIV  = 7'b0000010,
        ST_ANGLE = 7'b0000100,
        ST_WALK  = 7'b0001000,
        ST_MUL   = 7'b0010000,
        ST_HDIV  = 7'b0100000,
        ST_OUT   = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    // configuration registers
    logic [63:0] map_reg;
    logic [14:0] fov_reg;
    logic [10:0] rays_reg;
    logic [7:0]  scale_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            map_reg   <= WALL_MAP_RST;
            fov_reg   <= FOV_RST;
            rays_reg  <= RAYS_RST;
            scale_reg <= SCALE_RST;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_WALL_MAP: map_reg   <= cfg_data;
                REG_FOV:      fov_reg   <= cfg_data[14:0];
                REG_RAYS:     rays_reg  <= cfg_data[10:0];
                REG_SCALE:    scale_reg <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // request working registers
    logic [15:0]        view_reg;
    logic [15:0]        ray_reg;
    logic signed [19:0] x_reg, y_reg;
    logic signed [15:0] dx_reg, dy_reg;
    logic [SW-1:0]      steps_reg;
    logic               left_reg;
    logic signed [23:0] corr_reg;

    // shared divider
    logic            div_start, div_done;
    logic [NUMW-1:0] div_num, div_quot;
    logic [18:0]     div_den;

    rcwc_divider #(.NW(NUMW), .DW(19)) u_div (
        .aclk, .aresetn, .start(div_start), .numer(div_num), .denom(div_den),
        .done(div_done), .quot(div_quot)
    );

    // walk step datapath
    logic signed [19:0] nx, ny;
    logic               out_map, hit;
    logic [5:0]         map_idx;
    assign nx = x_reg + 20'(dx_reg);
    assign ny = y_reg + 20'(dy_reg);
    assign out_map = (nx < 0) || (nx >= 20'sd0 + 20'(LIM)) ||
                     (ny < 0) || (ny >= 20'sd0 + 20'(LIM));
    assign map_idx = {ny[16:14], nx[16:14]};
    assign hit     = map_reg[map_idx];

    logic signed [15:0] cosd;
    assign cosd = sin_q14(view_reg - ray_reg + 16'd16384);

    // corrected distance, steps * cos in Q.14
    logic signed [23:0] corr;
    assign corr = 24'($signed({1'b0, steps_reg})) * 24'(cosd);

    logic [10:0] rc;
    assign rc = (rays_reg == '0) ? 11'd1 : rays_reg;

    always_comb begin
        state_next = state_reg;
        div_start  = 1'b0;
        div_num    = '0;
        div_den    = '0;
        unique case (state_reg)
            ST_IDLE: if (s_valid && s_ready) begin
                state_next = ST_ODIV;
                div_start  = 1'b1;
                div_num    = NUMW'(s_data.column) * NUMW'(fov_reg);
                div_den    = 19'(rc);
            end
            ST_ODIV:  if (div_done) state_next = ST_ANGLE;
            ST_ANGLE: state_next = ST_WALK;
            ST_WALK:  if (out_map || hit || (steps_reg == SW'(MAX_STEPS - 1)))
                          state_next = ST_MUL;
            ST_MUL: begin
                if (corr <= 0) state_next = ST_OUT;
                else begin
                    state_next = ST_HDIV;
                    div_start  = 1'b1;
                    div_num    = NUMW'({11'(MAP_SIZE) * scale_reg, 14'd0});
                    div_den    = corr[18:0];
                end
            end
            ST_HDIV:  if (div_done) state_next = ST_OUT;
            ST_OUT:   if (!m_valid || m_ready) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    logic [NUMW-1:0] quot_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            m_valid   <= 1'b0;
        end else begin
            state_reg <= state_next;
            // load in ST_OUT, hold while the receiver stalls
            m_valid   <= (state_reg == ST_OUT) || (m_valid && !m_ready);
        end
        case (state_reg)
            ST_IDLE: begin
                view_reg <= s_data.view_angle;
                x_reg    <= 20'({s_data.pos_x, 2'b00});
                y_reg    <= 20'({s_data.pos_y, 2'b00});
            end
            ST_ODIV: if (div_done)
                ray_reg <= view_reg - 16'(fov_reg >> 1) + div_quot[15:0];
            ST_ANGLE: begin
                dx_reg    <= sin_q14(ray_reg + 16'd16384);
                dy_reg    <= sin_q14(ray_reg);
                steps_reg <= '0;
                left_reg  <= 1'b1;
            end
            ST_WALK: begin
                x_reg     <= nx;
                y_reg     <= ny;
                steps_reg <= steps_reg + 1'b1;
                left_reg  <= out_map || !hit;
            end
            ST_MUL: begin
                corr_reg <= corr;
                quot_reg <= '1;
            end
            ST_HDIV: if (div_done) quot_reg <= div_quot;
            ST_OUT: if (!m_valid || m_ready) begin
                m_data.wall_height      <= (corr_reg <= 0 || quot_reg > 25'd4095)
                                           ? 12'hFFF : quot_reg[11:0];
                m_data.height_saturated <= (corr_reg <= 0 || quot_reg > 25'd4095);
                m_data.step_count       <= 4'(steps_reg);
                m_data.left_map         <= left_reg;
            end
            default: ;
        endcase
    end

    assign s_ready = (state_reg == ST_IDLE);

    // assertions
    a_one_hot: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot(state_reg)) else $error("state not one-hot");
    a_steps: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_MUL) |-> (steps_reg >= SW'(1) && steps_reg <= SW'(MAX_STEPS)))
        else $error("step count out of range");
    a_div_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_ODIV) |=> (state_reg == ST_ODIV || state_reg == ST_ANGLE))
        else $error("offset division left early");
endmodule

FILE: tb/testbench.sv
// Self-checking testbench for raycast_wall_column.
// Depends on rcwc_pkg and the raycast_wall_column RTL; predicts each column's
// wall height in SV and checks results in order under random idling and stalls.
`timescale 1ns / 1ps

module testbench;
    import rcwc_pkg::*;

    localparam int  MAP_N       = 8;
    localparam int  STEP_LIMIT  = 12;
    localparam int  CYCLE_LIMIT = 1500000;
    localparam int  SETTLE      = 100;    // beyond the worst request latency

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    rcwc_in_t    s_data;
    logic        m_valid;
    logic        m_ready;
    rcwc_out_t   m_data;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [63:0] cfg_data;

    raycast_wall_column dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // quarter-wave sine magnitudes, Q1.14
    const int sine_mag[65] = '{
            0,   402,   804,  1205,  1606,  2006,  2404,  2801,
         3196,  3590,  3981,  4370,  4756,  5139,  5520,  5897,
         6270,  6639,  7005,  7366,  7723,  8076,  8423,  8765,
         9102,  9434,  9760, 10080, 10394, 10702, 11003, 11297,
        11585, 11866, 12140, 12406, 12665, 12916, 13160, 13395,
        13623, 13842, 14053, 14256, 14449, 14635, 14811, 14978,
        15137, 15286, 15426, 15557, 15679, 15791, 15893, 15986,
        16069, 16143, 16207, 16261, 16305, 16340, 16364, 16379,
        16384
    };

    // local copy of the configuration registers
    logic [63:0] cur_map;
    logic [14:0] cur_fov;
    logic [10:0] cur_rays;
    logic [7:0]  cur_scale;

    rcwc_out_t   column_q[$];     // expected column results, oldest first
    int          mismatches;
    int          cycles;
    int          idle_pct;        // sender idle chance per request
    int          stall_pct;       // receiver stall chance per cycle
    int          hold_req;        // long receiver hold-off, picked up below
    int          hold_cnt;

    always begin
        aclk = 1'b1; #5;
        aclk = 1'b0; #5;
    end

    // binary angle to signed Q1.14 sine, 256 steps per turn
    function automatic int sine_of(logic [15:0] ang);
        logic [7:0] idx;
        int         v;
        idx = ang[15:8];
        v = idx[6] ? sine_mag[64 - idx[5:0]] : sine_mag[idx[5:0]];
        return idx[7] ? -v : v;
    endfunction

    function automatic rcwc_out_t cast_column(rcwc_in_t req);
        rcwc_out_t   r;
        int          rays, offs, dx, dy, x, y, steps, cosd;
        bit          hit_or_out, left;
        logic [15:0] ray;
        longint      corr, num, h;
        rays  = (cur_rays == 0) ? 1 : cur_rays;
        offs  = (int'(req.column) * int'(cur_fov)) / rays;
        ray   = req.view_angle - 16'(cur_fov >> 1) + 16'(offs);
        dx    = sine_of(ray + 16'd16384);
        dy    = sine_of(ray);
        x     = int'(req.pos_x) << 2;
        y     = int'(req.pos_y) << 2;
        steps = 0;
        left  = 1'b1;
        hit_or_out = 1'b0;
        while (!hit_or_out && steps < STEP_LIMIT) begin
            x += dx;
            y += dy;
            steps++;
            if (x < 0 || x >= (MAP_N << 14) || y < 0 || y >= (MAP_N << 14)) begin
                left = 1'b1;
                hit_or_out = 1'b1;
            end else if (cur_map[((y >> 14) & 7) * 8 + ((x >> 14) & 7)]) begin
                left = 1'b0;
                hit_or_out = 1'b1;
            end
        end
        // fish-eye correction by cos(view - ray)
        cosd = sine_of(req.view_angle - ray + 16'd16384);
        corr = longint'(steps) * longint'(cosd);
        r.height_saturated = 1'b0;
        if (corr <= 0) begin
            h = 4095;
            r.height_saturated = 1'b1;
        end else begin
            num = (longint'(MAP_N) * longint'(cur_scale)) << 14;
            h = num / corr;
            if (h > 4095) begin
                h = 4095;
                r.height_saturated = 1'b1;
            end
        end
        r.wall_height = h[11:0];
        r.step_count  = steps[3:0];
        r.left_map    = left;
        return r;
    endfunction

    // Request monitor and result checker. Both sample pre-edge values.
    always @(posedge aclk) begin
        rcwc_out_t want;
        if (aresetn) begin
            if (s_valid && s_ready)
                column_q.push_back(cast_column(s_data));
            if (m_valid && m_ready) begin
                if (column_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result %p", m_data);
                end else begin
                    want = column_q.pop_front();
                    if (m_data.wall_height !== want.wall_height ||
                        m_data.height_saturated !== want.height_saturated ||
                        m_data.step_count !== want.step_count ||
                        m_data.left_map !== want.left_map) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: expected %p, got %p", want, m_data);
                    end
                end
            end
        end
    end

    // Receiver: random stalls, plus an occasional long hold-off.
    always @(posedge aclk) begin
        if (hold_req > 0) begin
            hold_cnt = hold_req;
            hold_req = 0;
        end
        if (hold_cnt > 0) begin
            m_ready  <= 1'b0;
            hold_cnt--;
        end else begin
            m_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Watchdog
    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("raycast_wall_column regression: fail");
            $finish;
        end
    end

    // Offer one request; valid stays up after acceptance until the next call.
    task automatic send_request(rcwc_in_t req);
        if ($urandom_range(99) < idle_pct) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= req;
        do @(posedge aclk); while (!s_ready);
    endtask

    // Stop offering and wait for every expected column to come back.
    task automatic drain;
        s_valid <= 1'b0;
        @(posedge aclk);
        while (column_q.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [63:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        case (idx)
            REG_WALL_MAP: cur_map   = val;
            REG_FOV:      cur_fov   = val[14:0];
            REG_RAYS:     cur_rays  = val[10:0];
            REG_SCALE:    cur_scale = val[7:0];
            default: ;
        endcase
    endtask

    task automatic set_config(logic [63:0] m, logic [14:0] f, logic [10:0] n,
                              logic [7:0] sc);
        write_reg(REG_WALL_MAP, m);
        write_reg(REG_FOV, {49'd0, f});
        write_reg(REG_RAYS, {53'd0, n});
        write_reg(REG_SCALE, {56'd0, sc});
    endtask

    function automatic rcwc_in_t mk_req(int px, int py, int va, int col);
        rcwc_in_t q;
        q.pos_x = 15'(px); q.pos_y = 15'(py); q.view_angle = 16'(va); q.column = 10'(col);
        return q;
    endfunction

    function automatic rcwc_in_t random_req();
        rcwc_in_t q;
        q.pos_x      = 15'($urandom);
        q.pos_y      = 15'($urandom);
        q.view_angle = 16'($urandom);
        // mostly a column inside the field of view, sometimes beyond it
        if ($urandom_range(9) < 8 && cur_rays != 0)
            q.column = 10'($urandom_range(cur_rays > 1024 ? 1023 : cur_rays - 1));
        else
            q.column = 10'($urandom);
        return q;
    endfunction

    // Directed corners under reset and extreme settings.
    task automatic test_directed;
        idle_pct = 0; stall_pct = 0;
        send_request(mk_req(0, 0, 0, 0));
        send_request(mk_req(32767, 32767, 65535, 1023));
        send_request(mk_req(16384, 16384, 16384, 60));
        send_request(mk_req(4096, 28672, 49152, 119));
        send_request(mk_req(20000, 4100, 32768, 500));
        drain();
        // open map: walk leaves the map; zero height scale
        set_config(64'd0, 15'd1, 11'd1, 8'd0);
        send_request(mk_req(0, 0, 0, 0));
        send_request(mk_req(16384, 16384, 8192, 1));
        send_request(mk_req(2048, 2048, 8192, 0));
        drain();
        // all walls, widest view, one ray: column beyond ray count
        set_config(64'hFFFF_FFFF_FFFF_FFFF, 15'd32767, 11'd1, 8'd255);
        send_request(mk_req(16384, 16384, 0, 0));
        send_request(mk_req(16384, 16384, 0, 1023));
        send_request(mk_req(100, 32000, 40000, 3));
        drain();
        // zero ray count, non-positive corrected distance
        set_config(64'h0000_0018_1800_0000, 15'd32767, 11'd0, 8'd255);
        send_request(mk_req(16384, 16384, 0, 1));
        send_request(mk_req(16384, 16384, 0, 2));
        send_request(mk_req(0, 32767, 65535, 1023));
        send_request(mk_req(32767, 0, 12345, 700));
        drain();
        set_config(WALL_MAP_RST, FOV_RST, RAYS_RST, SCALE_RST);
    endtask

    // Long receiver hold-off while requests keep coming; then a full pause.
    task automatic test_backpressure;
        idle_pct = 0; stall_pct = 0;
        hold_req = 400;
        repeat (20) send_request(random_req());
        drain();
    endtask

    task automatic random_phase(int n, int idle, int stall);
        idle_pct  = idle;
        stall_pct = stall;
        repeat (n) begin
            // occasionally pause until the block has returned everything
            if ($urandom_range(99) == 0) begin
                s_valid <= 1'b0;
                @(posedge aclk);
                while (column_q.size() != 0) @(posedge aclk);
            end
            send_request(random_req());
        end
        drain();
    endtask

    task automatic test_random;
        random_phase(375, 0, 0);
        set_config({$urandom, $urandom}, 15'd32767, 11'd1024, 8'd255);
        random_phase(375, 54, 0);
        set_config({$urandom, $urandom} | WALL_MAP_RST, 15'($urandom_range(1, 32767)),
                   11'($urandom_range(1, 1024)), 8'($urandom_range(1, 255)));
        random_phase(375, 0, 54);
        set_config({$urandom, $urandom} & {$urandom, $urandom}, 15'd1, 11'd1, 8'd1);
        random_phase(375, 32, 32);
    endtask

    initial begin
        aresetn   = 1'b0;
        s_valid   = 1'b0;
        s_data    = '0;
        m_ready   = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = REG_WALL_MAP;
        cfg_data  = '0;
        cur_map   = WALL_MAP_RST;
        cur_fov   = FOV_RST;
        cur_rays  = RAYS_RST;
        cur_scale = SCALE_RST;
        mismatches = 0;
        cycles    = 0;
        idle_pct  = 0;
        stall_pct = 0;
        hold_req  = 0;
        hold_cnt  = 0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed();
        test_backpressure();
        test_random();

        if (mismatches == 0 && column_q.size() == 0) begin
            $display("raycast_wall_column regression: pass");
        end else begin
            $display("raycast_wall_column regression: fail");
        end
        $finish;
    end

endmodule
